[rtl/core/prack_pkg.sv]
// Shared types, codes and constants of the packet radio ack link controller.
package prack_pkg;

    localparam int MAX_PAYLOAD_DEF = 64;

    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 48;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [2:0] {
        FN_SEND      = 3'd0,
        FN_TX_DONE   = 3'd1,
        FN_RX_FRAME  = 3'd2,
        FN_READ      = 3'd3,
        FN_ACK_POLL  = 3'd4,
        FN_GIVE_UP   = 3'd5,
        FN_SET_MODE  = 3'd6
    } func_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_BUSY      = 3'd2,
        ST_NO_MSG    = 3'd3,
        ST_TOO_LONG  = 3'd4,
        ST_BUF_SHORT = 3'd5,
        ST_ACK_TMO   = 3'd6
    } status_t;

    // radio modes; default_mode may hold any 3-bit code, so these stay plain constants
    localparam logic [2:0] MODE_SLEEP   = 3'd0;
    localparam logic [2:0] MODE_STANDBY = 3'd1;
    localparam logic [2:0] MODE_FS      = 3'd2;
    localparam logic [2:0] MODE_TX      = 3'd3;
    localparam logic [2:0] MODE_RX      = 3'd4;
    localparam logic [2:0] MODE_LISTEN  = 3'd5;

    localparam logic [CFG_INDEX_W-1:0] CFG_DEFAULT_MODE  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACK_TIMEOUT   = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_TITLE     = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_RX_LENGTH = 8'd3;

    typedef struct packed {
        logic [2:0]  default_mode;
        logic [15:0] ack_timeout_ms;
        logic [5:0]  max_title;
        logic [6:0]  max_rx_length;
    } cfg_t;

    typedef struct packed {
        func_t       func;
        logic [31:0] now_ms;
        logic [7:0]  length;
        logic [5:0]  title;
        logic        want_ack;
        logic [7:0]  rx_frame_length;
        logic        rx_is_ack;
        logic        rx_want_ack;
        logic [5:0]  rx_title;
        logic [7:0]  rx_rssi_raw;
        logic [2:0]  new_mode;
    } item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  radio_mode;
        logic [7:0]  frame_length;
        logic [5:0]  frame_title;
        logic        frame_want_ack;
        logic        frame_is_ack;
        logic [7:0]  msg_length;
        logic [5:0]  msg_title;
        logic [7:0]  msg_rssi;
        logic        waiting_ack;
        logic        ack_received;
        logic        message_ready;
    } res_t;

    typedef struct packed {
        logic        tx_msg_busy;
        logic        tx_ack_busy;
        logic        awaiting_ack;
        logic        ack_seen;
        logic        msg_held;
        logic [2:0]  mode_now;
        logic [31:0] last_tx_time;
        logic [7:0]  held_length;
        logic [5:0]  held_title;
        logic        held_want_ack;
        logic [7:0]  held_rssi;
    } link_state_t;

    // statistics events of one step
    typedef struct packed {
        logic        sent;
        logic        received;
        logic        stray_ack;
        logic        ack;
        logic [31:0] wait_ms;
        logic [31:0] rx_time;
    } stat_evt_t;

    typedef struct packed {
        logic [31:0] sent_count;
        logic [31:0] received_count;
        logic [31:0] unexpected_ack_count;
        logic [31:0] ack_count;
        logic [31:0] ack_wait_sum;
        logic [31:0] ack_wait_max;
        logic [31:0] ack_wait_last;
        logic [31:0] held_rx_time;
    } stats_t;

endpackage

[rtl/core/prack_step.sv]
// Next-state and result logic for one link event.
module prack_step #(
    parameter int MAX_PAYLOAD = prack_pkg::MAX_PAYLOAD_DEF
) (
    input  prack_pkg::link_state_t st,
    input  prack_pkg::cfg_t        cfg,
    input  prack_pkg::item_t       item,
    output prack_pkg::link_state_t st_next,
    output prack_pkg::res_t        res,
    output prack_pkg::stat_evt_t   evt
);
    import prack_pkg::*;

    // mode change that cannot wait: listen is refused
    function automatic logic [2:0] fast_mode(input logic [2:0] cur, input logic [2:0] m);
        fast_mode = (m == MODE_LISTEN) ? cur : m;
    endfunction

    logic [31:0] since_tx;
    logic [2:0]  status;
    logic [7:0]  f_len;
    logic [5:0]  f_title;
    logic        f_want;
    logic        f_ack;
    logic        tx_busy;
    logic        mode_ok;

    assign since_tx = item.now_ms - st.last_tx_time;
    assign tx_busy  = st.tx_msg_busy | st.tx_ack_busy;
    assign mode_ok  = (item.new_mode == MODE_SLEEP) || (item.new_mode == MODE_STANDBY) ||
                      (item.new_mode == MODE_FS) || (item.new_mode == MODE_RX) ||
                      (item.new_mode == MODE_LISTEN);

    always_comb
    begin
        st_next = st;
        status  = ST_OK;
        f_len   = '0;
        f_title = '0;
        f_want  = 1'b0;
        f_ack   = 1'b0;
        evt     = '0;
        evt.wait_ms = since_tx;
        evt.rx_time = item.now_ms;

        unique case (item.func)
            FN_SEND:
            begin
                if (item.length == 8'd0)
                    status = ST_EMPTY;
                else if (item.length > 8'(MAX_PAYLOAD))
                    status = ST_TOO_LONG;
                else if (tx_busy)
                    status = ST_BUSY;
                else
                begin
                    f_len   = item.length + 8'd1;
                    f_title = (item.title > cfg.max_title) ? 6'd0 : item.title;
                    f_want  = item.want_ack;
                    st_next.mode_now     = MODE_TX;
                    st_next.tx_msg_busy  = 1'b1;
                    st_next.awaiting_ack = item.want_ack;
                    st_next.ack_seen     = 1'b0;
                    st_next.last_tx_time = item.now_ms;
                end
            end
            FN_TX_DONE:
            begin
                if (st.tx_msg_busy)
                begin
                    st_next.mode_now = fast_mode(st.mode_now,
                                                 st.awaiting_ack ? MODE_RX : cfg.default_mode);
                    st_next.tx_msg_busy = 1'b0;
                    evt.sent = 1'b1;
                end
                else if (st.tx_ack_busy)
                begin
                    st_next.mode_now    = fast_mode(st.mode_now, cfg.default_mode);
                    st_next.tx_ack_busy = 1'b0;
                end
            end
            FN_RX_FRAME:
            begin
                if (!tx_busy && (st.mode_now == MODE_RX || st.mode_now == MODE_LISTEN))
                begin
                    if (st.awaiting_ack && item.rx_is_ack)
                    begin
                        st_next.mode_now     = fast_mode(MODE_STANDBY, cfg.default_mode);
                        st_next.awaiting_ack = 1'b0;
                        st_next.ack_seen     = 1'b1;
                        evt.ack = 1'b1;
                    end
                    else if (item.rx_is_ack)
                        evt.stray_ack = 1'b1;
                    else
                    begin
                        st_next.mode_now      = MODE_STANDBY;
                        st_next.msg_held      = 1'b1;
                        st_next.held_length   = (item.rx_frame_length == 8'd0) ? 8'd0 :
                                                item.rx_frame_length - 8'd1;
                        st_next.held_title    = item.rx_title;
                        st_next.held_want_ack = item.rx_want_ack;
                        st_next.held_rssi     = 8'd0 - {1'b0, item.rx_rssi_raw[7:1]};
                        evt.received = 1'b1;
                    end
                end
            end
            FN_READ:
            begin
                if (!st.msg_held)
                    status = ST_NO_MSG;
                else if ({1'b0, cfg.max_rx_length} < st.held_length)
                    status = ST_TOO_LONG;
                else if (item.length < st.held_length)
                    status = ST_BUF_SHORT;
                else if (st.held_want_ack && st.tx_msg_busy)
                    status = ST_BUSY;
                else if (st.held_want_ack)
                begin
                    f_len = 8'd1;
                    f_ack = 1'b1;
                    st_next.mode_now    = MODE_TX;
                    st_next.tx_ack_busy = 1'b1;
                    st_next.msg_held    = 1'b0;
                end
                else
                begin
                    st_next.mode_now = cfg.default_mode;
                    st_next.msg_held = 1'b0;
                end
            end
            FN_ACK_POLL:
            begin
                if (st.awaiting_ack && (since_tx > {16'd0, cfg.ack_timeout_ms}))
                begin
                    st_next.awaiting_ack = 1'b0;
                    status = ST_ACK_TMO;
                end
            end
            FN_GIVE_UP:
                st_next.awaiting_ack = 1'b0;
            FN_SET_MODE:
            begin
                if (mode_ok)
                    st_next.mode_now = item.new_mode;
            end
            default:
            begin
                // unused function code: no effect
            end
        endcase
    end

    always_comb
    begin
        res.status         = status;
        res.radio_mode     = st_next.mode_now;
        res.frame_length   = f_len;
        res.frame_title    = f_title;
        res.frame_want_ack = f_want;
        res.frame_is_ack   = f_ack;
        res.msg_length     = st_next.held_length;
        res.msg_title      = st_next.held_title;
        res.msg_rssi       = st_next.held_rssi;
        res.waiting_ack    = st_next.awaiting_ack;
        res.ack_received   = st_next.ack_seen;
        res.message_ready  = st_next.msg_held;
    end

endmodule

[rtl/core/prack_stats.sv]
// Traffic counters and ack wait statistics.
module prack_stats (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  prack_pkg::stat_evt_t evt,
    output prack_pkg::stats_t    stats
);
    import prack_pkg::*;

    stats_t stats_reg;
    stats_t stats_next;

    always_comb
    begin
        stats_next = stats_reg;
        if (en)
        begin
            if (evt.sent)
                stats_next.sent_count = stats_reg.sent_count + 32'd1;
            if (evt.stray_ack)
                stats_next.unexpected_ack_count = stats_reg.unexpected_ack_count + 32'd1;
            if (evt.received)
            begin
                stats_next.received_count = stats_reg.received_count + 32'd1;
                stats_next.held_rx_time   = evt.rx_time;
            end
            if (evt.ack)
            begin
                stats_next.ack_wait_last = evt.wait_ms;
                if (evt.wait_ms > stats_reg.ack_wait_max)
                    stats_next.ack_wait_max = evt.wait_ms;
                stats_next.ack_count    = stats_reg.ack_count + 32'd1;
                stats_next.ack_wait_sum = stats_reg.ack_wait_sum + evt.wait_ms;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stats_reg <= '0;
        else
            stats_reg <= stats_next;
    end

    assign stats = stats_reg;

endmodule

[rtl/core/packet_radio_ack_link_controller.sv]
// Top level of the packet radio ack link controller: channels, registers, state.
//
//  channel | direction | transfer when          | payload
//  --------+-----------+------------------------+-------------------------------
//  s_axis  | in        | s_axis_tvalid & tready | tuser func, tdata event fields
//  m_axis  | out       | m_axis_tvalid & tready | tdata status, mode, frame, msg
//  cfg     | in        | cfg_valid & cfg_ready  | cfg_index, cfg_data
//
// One event per cycle while results are taken; path: input register, result register.
// Each event's state update is registered with its result, so the next event can use it.
// Reset: all flags clear, mode standby, held fields and statistics zero, config defaults.
// A stalled result holds in the result register; the input register still takes
// one more event and then s_axis_tready drops until the result is taken.
// cfg_ready is always high; writes are expected only while the block is idle.
module packet_radio_ack_link_controller #(
    parameter int MAX_PAYLOAD = prack_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [31:0] now_ms, [39:32] length, [45:40] title, [46] want_ack,
    // [54:47] rx_frame_length, [55] rx_is_ack, [56] rx_want_ack,
    // [62:57] rx_title, [70:63] rx_rssi_raw, [73:71] new_mode, [79:74] zero
    input  logic [prack_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // [2:0] func
    input  logic [2:0]                          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [2:0] status, [5:3] radio_mode, [13:6] frame_length, [19:14] frame_title,
    // [20] frame_want_ack, [21] frame_is_ack, [29:22] msg_length, [35:30] msg_title,
    // [43:36] msg_rssi, [44] waiting_ack, [45] ack_received, [46] message_ready,
    // [47] zero
    output logic [prack_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [prack_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [prack_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import prack_pkg::*;

    // input register
    item_t       in_item_reg;
    logic        in_valid_reg;
    // result register
    res_t        out_res_reg;
    logic        out_valid_reg;
    // link state and config
    link_state_t st_reg;
    link_state_t st_next;
    cfg_t        cfg_reg;

    res_t        res_next;
    stat_evt_t   evt;
    stats_t      stats;
    item_t       in_item;
    logic        advance;

    // event moves from the input register into the result register
    assign advance       = in_valid_reg & (~out_valid_reg | m_axis_tready);
    assign s_axis_tready = ~in_valid_reg | advance;
    assign cfg_ready     = 1'b1;

    always_comb
    begin
        in_item.func            = func_t'(s_axis_tuser);
        in_item.now_ms          = s_axis_tdata[31:0];
        in_item.length          = s_axis_tdata[39:32];
        in_item.title           = s_axis_tdata[45:40];
        in_item.want_ack        = s_axis_tdata[46];
        in_item.rx_frame_length = s_axis_tdata[54:47];
        in_item.rx_is_ack       = s_axis_tdata[55];
        in_item.rx_want_ack     = s_axis_tdata[56];
        in_item.rx_title        = s_axis_tdata[62:57];
        in_item.rx_rssi_raw     = s_axis_tdata[70:63];
        in_item.new_mode        = s_axis_tdata[73:71];
    end

    prack_step #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_step (
        .st      (st_reg),
        .cfg     (cfg_reg),
        .item    (in_item_reg),
        .st_next (st_next),
        .res     (res_next),
        .evt     (evt)
    );

    prack_stats u_stats (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (advance),
        .evt   (evt),
        .stats (stats)
    );

    // handshake control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
            in_item_reg <= in_item;
        if (advance)
            out_res_reg <= res_next;
    end

    // link state: everything clear, radio in standby
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, MODE_STANDBY,
                        32'd0, 8'd0, 6'd0, 1'b0, 8'd0};
        else if (advance)
            st_reg <= st_next;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.default_mode   <= MODE_STANDBY;
            cfg_reg.ack_timeout_ms <= 16'd30;
            cfg_reg.max_title      <= 6'd63;
            cfg_reg.max_rx_length  <= 7'd64;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_DEFAULT_MODE:  cfg_reg.default_mode   <= cfg_data[2:0];
                CFG_ACK_TIMEOUT:   cfg_reg.ack_timeout_ms <= cfg_data[15:0];
                CFG_MAX_TITLE:     cfg_reg.max_title      <= cfg_data[5:0];
                CFG_MAX_RX_LENGTH: cfg_reg.max_rx_length  <= cfg_data[6:0];
                default:
                begin
                    // unmapped index: ignored
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    // first field in the lowest bits
    assign m_axis_tdata  = {1'b0,
                            out_res_reg.message_ready,
                            out_res_reg.ack_received,
                            out_res_reg.waiting_ack,
                            out_res_reg.msg_rssi,
                            out_res_reg.msg_title,
                            out_res_reg.msg_length,
                            out_res_reg.frame_is_ack,
                            out_res_reg.frame_want_ack,
                            out_res_reg.frame_title,
                            out_res_reg.frame_length,
                            out_res_reg.radio_mode,
                            out_res_reg.status};

    // only one transmission can be in flight
    a_one_tx: assert property (@(posedge clk) disable iff (!rst_n)
        !(st_reg.tx_msg_busy && st_reg.tx_ack_busy))
        else $error("message and ack transmissions both busy");

    // a frame on the air always leaves the radio in tx
    a_frame_tx_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_res_reg.frame_length != 8'd0) |->
        (out_res_reg.radio_mode == MODE_TX))
        else $error("frame sent without tx mode");

    // largest ack wait never below the latest one
    a_wait_max: assert property (@(posedge clk) disable iff (!rst_n)
        stats.ack_wait_max >= stats.ack_wait_last)
        else $error("ack wait max below last wait");

    // a stalled result keeps its contents
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(out_res_reg))
        else $error("stalled result changed");

endmodule

[tb/prack_link_checker.sv]
// Checker for the packet radio ack link controller: tracks link state and compares results.
`timescale 1ns / 100ps

module prack_link_checker
    import prack_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic [2:0]             s_axis_tuser,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     mismatches,
    output int                     results_due
);

    cfg_t        link_cfg;
    res_t        awaited_results[$];

    logic        tx_msg_busy;
    logic        tx_ack_busy;
    logic        awaiting_ack;
    logic        ack_seen;
    logic        msg_held;
    logic [2:0]  mode_now;
    logic [31:0] last_tx_time;
    logic [7:0]  held_length;
    logic [5:0]  held_title;
    logic        held_want_ack;
    logic [7:0]  held_rssi;

    function automatic item_t unpack_event(input logic [IN_TDATA_W-1:0] d,
                                           input logic [2:0] fn);
        item_t ev;
        ev.func            = func_t'(fn);
        ev.now_ms          = d[31:0];
        ev.length          = d[39:32];
        ev.title           = d[45:40];
        ev.want_ack        = d[46];
        ev.rx_frame_length = d[54:47];
        ev.rx_is_ack       = d[55];
        ev.rx_want_ack     = d[56];
        ev.rx_title        = d[62:57];
        ev.rx_rssi_raw     = d[70:63];
        ev.new_mode        = d[73:71];
        return ev;
    endfunction

    // listen cannot be entered without a wait
    function automatic void enter_fast(input logic [2:0] m);
        if (m != MODE_LISTEN)
            mode_now = m;
    endfunction

    function automatic res_t link_response(input item_t ev);
        res_t        r;
        logic [31:0] waited;
        r = '0;
        r.status = ST_OK;
        case (ev.func)
            FN_SEND:
            begin
                if (ev.length == 8'd0)
                    r.status = ST_EMPTY;
                else if (ev.length > 8'(MAX_PAYLOAD_DEF))
                    r.status = ST_TOO_LONG;
                else if (tx_msg_busy || tx_ack_busy)
                    r.status = ST_BUSY;
                else
                begin
                    r.frame_length   = ev.length + 8'd1;
                    r.frame_title    = (ev.title > link_cfg.max_title) ? 6'd0 : ev.title;
                    r.frame_want_ack = ev.want_ack;
                    mode_now         = MODE_TX;
                    tx_msg_busy      = 1'b1;
                    awaiting_ack     = ev.want_ack;
                    ack_seen         = 1'b0;
                    last_tx_time     = ev.now_ms;
                end
            end
            FN_TX_DONE:
            begin
                if (tx_msg_busy)
                begin
                    enter_fast(awaiting_ack ? MODE_RX : link_cfg.default_mode);
                    tx_msg_busy = 1'b0;
                end
                else if (tx_ack_busy)
                begin
                    enter_fast(link_cfg.default_mode);
                    tx_ack_busy = 1'b0;
                end
            end
            FN_RX_FRAME:
            begin
                if (!tx_msg_busy && !tx_ack_busy &&
                    (mode_now == MODE_RX || mode_now == MODE_LISTEN))
                begin
                    if (awaiting_ack && ev.rx_is_ack)
                    begin
                        mode_now     = MODE_STANDBY;
                        awaiting_ack = 1'b0;
                        ack_seen     = 1'b1;
                        enter_fast(link_cfg.default_mode);
                    end
                    else if (!ev.rx_is_ack)
                    begin
                        // stray acks leave everything as it was
                        mode_now      = MODE_STANDBY;
                        msg_held      = 1'b1;
                        held_length   = (ev.rx_frame_length != 8'd0) ?
                                        ev.rx_frame_length - 8'd1 : 8'd0;
                        held_title    = ev.rx_title;
                        held_want_ack = ev.rx_want_ack;
                        held_rssi     = 8'd0 - {1'b0, ev.rx_rssi_raw[7:1]};
                    end
                end
            end
            FN_READ:
            begin
                if (!msg_held)
                    r.status = ST_NO_MSG;
                else if ({1'b0, link_cfg.max_rx_length} < held_length)
                    r.status = ST_TOO_LONG;
                else if (ev.length < held_length)
                    r.status = ST_BUF_SHORT;
                else if (held_want_ack && tx_msg_busy)
                    r.status = ST_BUSY;
                else
                begin
                    if (held_want_ack)
                    begin
                        r.frame_length = 8'd1;
                        r.frame_is_ack = 1'b1;
                        mode_now       = MODE_TX;
                        tx_ack_busy    = 1'b1;
                    end
                    else
                        mode_now = link_cfg.default_mode;
                    msg_held = 1'b0;
                end
            end
            FN_ACK_POLL:
            begin
                waited = ev.now_ms - last_tx_time;
                if (awaiting_ack && waited > {16'd0, link_cfg.ack_timeout_ms})
                begin
                    awaiting_ack = 1'b0;
                    r.status     = ST_ACK_TMO;
                end
            end
            FN_GIVE_UP:
                awaiting_ack = 1'b0;
            FN_SET_MODE:
            begin
                if (ev.new_mode != MODE_TX && ev.new_mode <= MODE_LISTEN)
                    mode_now = ev.new_mode;
            end
            default:
                ;
        endcase
        r.radio_mode    = mode_now;
        r.msg_length    = held_length;
        r.msg_title     = held_title;
        r.msg_rssi      = held_rssi;
        r.waiting_ack   = awaiting_ack;
        r.ack_received  = ack_seen;
        r.message_ready = msg_held;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (want_v !== got_v)
        begin
            $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t got;
        res_t want;
        if (!rst_n)
        begin
            link_cfg.default_mode   = MODE_STANDBY;
            link_cfg.ack_timeout_ms = 16'd30;
            link_cfg.max_title      = 6'd63;
            link_cfg.max_rx_length  = 7'd64;
            tx_msg_busy   = 1'b0;
            tx_ack_busy   = 1'b0;
            awaiting_ack  = 1'b0;
            ack_seen      = 1'b0;
            msg_held      = 1'b0;
            mode_now      = MODE_STANDBY;
            last_tx_time  = '0;
            held_length   = '0;
            held_title    = '0;
            held_want_ack = 1'b0;
            held_rssi     = '0;
            awaited_results.delete();
            mismatches    = 0;
            results_due  <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_DEFAULT_MODE:  link_cfg.default_mode   = cfg_data[2:0];
                    CFG_ACK_TIMEOUT:   link_cfg.ack_timeout_ms = cfg_data[15:0];
                    CFG_MAX_TITLE:     link_cfg.max_title      = cfg_data[5:0];
                    CFG_MAX_RX_LENGTH: link_cfg.max_rx_length  = cfg_data[6:0];
                    default:           ;
                endcase
            end
            // compare before queuing, so a result never matches an event of the same edge
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.status         = m_axis_tdata[2:0];
                got.radio_mode     = m_axis_tdata[5:3];
                got.frame_length   = m_axis_tdata[13:6];
                got.frame_title    = m_axis_tdata[19:14];
                got.frame_want_ack = m_axis_tdata[20];
                got.frame_is_ack   = m_axis_tdata[21];
                got.msg_length     = m_axis_tdata[29:22];
                got.msg_title      = m_axis_tdata[35:30];
                got.msg_rssi       = m_axis_tdata[43:36];
                got.waiting_ack    = m_axis_tdata[44];
                got.ack_received   = m_axis_tdata[45];
                got.message_ready  = m_axis_tdata[46];
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: result expected none actual 0x%0h", $time, m_axis_tdata);
                    mismatches++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("status", 32'(want.status), 32'(got.status));
                    check_field("radio_mode", 32'(want.radio_mode), 32'(got.radio_mode));
                    check_field("frame_length", 32'(want.frame_length),
                                32'(got.frame_length));
                    check_field("frame_title", 32'(want.frame_title),
                                32'(got.frame_title));
                    check_field("frame_want_ack", 32'(want.frame_want_ack),
                                32'(got.frame_want_ack));
                    check_field("frame_is_ack", 32'(want.frame_is_ack),
                                32'(got.frame_is_ack));
                    check_field("msg_length", 32'(want.msg_length), 32'(got.msg_length));
                    check_field("msg_title", 32'(want.msg_title), 32'(got.msg_title));
                    check_field("msg_rssi", 32'(want.msg_rssi), 32'(got.msg_rssi));
                    check_field("waiting_ack", 32'(want.waiting_ack),
                                32'(got.waiting_ack));
                    check_field("ack_received", 32'(want.ack_received),
                                32'(got.ack_received));
                    check_field("message_ready", 32'(want.message_ready),
                                32'(got.message_ready));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                awaited_results.push_back(link_response(unpack_event(s_axis_tdata,
                                                                     s_axis_tuser)));
            results_due <= awaited_results.size();
        end
    end

endmodule

[tb/packet_radio_ack_link_controller_test.sv]
// Stimulus and verdict for the packet radio ack link controller.
`timescale 1ns / 100ps

module packet_radio_ack_link_controller_test;
    import prack_pkg::*;

    // cycles with no transfer on any channel before the run is declared hung
    localparam int WATCHDOG_LIMIT = 5000;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // [31:0] now_ms, [39:32] length, [45:40] title, [46] want_ack,
    // [54:47] rx_frame_length, [55] rx_is_ack, [56] rx_want_ack,
    // [62:57] rx_title, [70:63] rx_rssi_raw, [73:71] new_mode, [79:74] zero
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    // [2:0] func
    logic [2:0]             s_axis_tuser  = 3'd0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [2:0] status, [5:3] radio_mode, [13:6] frame_length, [19:14] frame_title,
    // [20] frame_want_ack, [21] frame_is_ack, [29:22] msg_length, [35:30] msg_title,
    // [43:36] msg_rssi, [44] waiting_ack, [45] ack_received, [46] message_ready
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index     = '0;
    logic [CFG_DATA_W-1:0]  cfg_data      = '0;

    int                     mismatches;
    int                     results_due;

    // sender side bookkeeping
    logic [31:0]            clock_ms    = 32'd100;
    logic [31:0]            sent_at     = 32'd0;
    int                     cur_timeout = 30;
    int                     burst_left  = 0;
    int                     posted      = 0;

    // receiver stall generator
    int                     stall_left    = 0;
    logic [1:0]             stall_kind    = 2'd0;
    logic [11:0]            stall_pattern = 12'h5A5;

    int                     idle_cycles   = 0;

    always #2 clk = ~clk;

    packet_radio_ack_link_controller uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    prack_link_checker monitor (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .results_due   (results_due)
    );

    // Receiver: each stretch of random length picks one behavior - always
    // ready, coin flips, a rotating 12-bit pattern, or rare stalls.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
            stall_kind    <= 2'd0;
            stall_pattern <= 12'h5A5;
        end
        else
        begin
            if (stall_left == 0)
            begin
                stall_kind    <= 2'($urandom_range(0, 3));
                stall_left    <= $urandom_range(32, 256);
                stall_pattern <= 12'($urandom) | 12'h001;  // never a pattern of all stalls
            end
            else
            begin
                stall_left    <= stall_left - 1;
                stall_pattern <= {stall_pattern[0], stall_pattern[11:1]};
            end
            case (stall_kind)
                2'd0:    m_axis_tready <= 1'b1;
                2'd1:    m_axis_tready <= 1'($urandom_range(0, 1));
                2'd2:    m_axis_tready <= stall_pattern[0];
                default: m_axis_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // Watchdog: any transfer on any channel restarts the count.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic [IN_TDATA_W-1:0] pack_event(input item_t ev);
        return {6'd0, ev.new_mode, ev.rx_rssi_raw, ev.rx_title, ev.rx_want_ack,
                ev.rx_is_ack, ev.rx_frame_length, ev.want_ack, ev.title, ev.length,
                ev.now_ms};
    endfunction

    // every field random, stamped with the current time; callers override what matters
    function automatic item_t rand_event(input func_t f);
        item_t ev;
        ev.func            = f;
        ev.now_ms          = clock_ms;
        ev.length          = 8'($urandom);
        ev.title           = 6'($urandom);
        ev.want_ack        = 1'($urandom);
        ev.rx_frame_length = 8'($urandom);
        ev.rx_is_ack       = 1'($urandom);
        ev.rx_want_ack     = 1'($urandom);
        ev.rx_title        = 6'($urandom);
        ev.rx_rssi_raw     = 8'($urandom);
        ev.new_mode        = 3'($urandom);
        return ev;
    endfunction

    // mostly short steps, a third of the time up to 1.5x the ack timeout plus 2
    function automatic void advance_clock();
        if ($urandom_range(0, 2) == 0)
            clock_ms += $urandom_range(0, cur_timeout + cur_timeout / 2 + 2);
        else
            clock_ms += $urandom_range(0, 12);
    endfunction

    // Sender: bursts of 1..24 transfers (sometimes 200) split by idle gaps.
    task automatic post(input item_t ev);
        if (burst_left == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : int'($urandom_range(1, 24));
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pack_event(ev);
        s_axis_tuser  <= ev.func;
        do @(posedge clk); while (!s_axis_tready);
        posted++;
    endtask

    task automatic do_send(input logic [7:0] len, input logic [5:0] ttl, input logic want);
        item_t ev;
        ev          = rand_event(FN_SEND);
        ev.length   = len;
        ev.title    = ttl;
        ev.want_ack = want;
        post(ev);
    endtask

    task automatic do_rx(input logic is_ack, input logic [7:0] rlen, input logic want,
                         input logic [5:0] ttl, input logic [7:0] rssi);
        item_t ev;
        ev                 = rand_event(FN_RX_FRAME);
        ev.rx_is_ack       = is_ack;
        ev.rx_frame_length = rlen;
        ev.rx_want_ack     = want;
        ev.rx_title        = ttl;
        ev.rx_rssi_raw     = rssi;
        post(ev);
    endtask

    task automatic do_read(input logic [7:0] cap);
        item_t ev;
        ev        = rand_event(FN_READ);
        ev.length = cap;
        post(ev);
    endtask

    task automatic do_mode(input logic [2:0] m);
        item_t ev;
        ev          = rand_event(FN_SET_MODE);
        ev.new_mode = m;
        post(ev);
    endtask

    task automatic do_plain(input func_t f);
        post(rand_event(f));
    endtask

    // random ack frame, any length and header bits
    task automatic do_rand_ack();
        do_rx(1'b1, 8'($urandom), 1'($urandom), 6'($urandom), 8'($urandom));
    endtask

    // wait for every awaited result; results_due is registered, so no early exit
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (results_due != 0);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic set_config(input logic [2:0] dm, input logic [15:0] tmo,
                              input logic [5:0] mt, input logic [6:0] mrx);
        drain();
        write_reg(CFG_DEFAULT_MODE, {13'd0, dm});
        write_reg(CFG_ACK_TIMEOUT, tmo);
        write_reg(CFG_MAX_TITLE, {10'd0, mt});
        write_reg(CFG_MAX_RX_LENGTH, {9'd0, mrx});
        cfg_valid   <= 1'b0;
        cur_timeout  = int'(tmo);
    endtask

    // Outbound exchange: send, usually finish the transmission, then an ack, a poll,
    // a give-up, a message or nothing while waiting.
    task automatic outbound_exchange();
        do_send(($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255))
                                             : 8'($urandom_range(1, 64)),
                6'($urandom_range(0, 63)), $urandom_range(0, 3) != 0);
        sent_at = clock_ms;
        if ($urandom_range(0, 4) == 0)
            do_send(8'($urandom_range(1, 64)), 6'($urandom), 1'($urandom));  // busy
        advance_clock();
        if ($urandom_range(0, 9) != 0)
            do_plain(FN_TX_DONE);
        advance_clock();
        case ($urandom_range(0, 4))
            0: do_rand_ack();
            1:
            begin
                // half the polls land right at the timeout edge
                if ($urandom_range(0, 1) != 0)
                    clock_ms = sent_at + 32'(cur_timeout) + $urandom_range(0, 1);
                do_plain(FN_ACK_POLL);
                advance_clock();
                if ($urandom_range(0, 1) != 0)
                    do_rand_ack();
            end
            2:
            begin
                do_plain(FN_GIVE_UP);
                do_rand_ack();
            end
            3: do_rx(1'b0, 8'($urandom_range(0, 66)), 1'($urandom), 6'($urandom),
                     8'($urandom));
            default: advance_clock();
        endcase
    endtask

    // Inbound exchange: open the receiver, take a message, read it with a buffer
    // close to its size and send the ack it asks for.
    task automatic inbound_exchange();
        logic [7:0] rlen;
        logic       want;
        int         held;
        int         cap;
        if ($urandom_range(0, 3) != 0)
            do_mode(($urandom_range(0, 1) != 0) ? MODE_RX : MODE_LISTEN);
        rlen = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(1, 66));
        want = 1'($urandom);
        do_rx(1'b0, rlen, want, 6'($urandom), 8'($urandom));
        advance_clock();
        held = (rlen == 8'd0) ? 0 : int'(rlen) - 1;
        cap  = held + int'($urandom_range(0, 4)) - 2;
        if (cap < 0)
            cap = 0;
        if (cap > 255)
            cap = 255;
        do_read(($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : 8'(cap));
        if (want && $urandom_range(0, 4) != 0)
            do_plain(FN_TX_DONE);
    endtask

    task automatic run_traffic(input int count);
        int start;
        start = posted;
        while (posted - start < count)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: outbound_exchange();
                4, 5, 6, 7: inbound_exchange();
                default:    post(rand_event(func_t'($urandom_range(0, 7))));
            endcase
            advance_clock();
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, reset configuration: standby default, 30 ms timeout.
        do_send(8'd0, 6'd63, 1'b1);          // empty frame
        do_send(8'd65, 6'd0, 1'b0);          // one byte over the payload limit
        do_read(8'd255);                     // nothing held
        do_plain(FN_TX_DONE);                // spurious transmit-done
        do_plain(FN_ACK_POLL);               // nothing awaited
        do_mode(MODE_TX);                    // tx is not a settable mode
        do_plain(func_t'(3'd7));             // unused function code
        do_send(8'd64, 6'd63, 1'b1);         // largest payload, ack requested at t=100
        do_send(8'd8, 6'd1, 1'b0);           // transmitter busy
        do_rx(1'b0, 8'd20, 1'b0, 6'd3, 8'd40);  // ignored while transmitting
        do_plain(FN_TX_DONE);                // into rx to wait for the ack
        clock_ms = 32'd130;
        do_plain(FN_ACK_POLL);               // exactly at the limit: still waiting
        clock_ms = 32'd131;
        do_plain(FN_ACK_POLL);               // one past: timed out
        do_rx(1'b1, 8'd1, 1'b0, 6'd0, 8'd0); // stray ack, mode stays rx
        do_rx(1'b0, 8'd0, 1'b1, 6'd63, 8'd255);  // zero length byte, wants an ack
        clock_ms = 32'hFFFF_FFF0;
        do_send(8'd1, 6'd0, 1'b1);
        do_read(8'd0);                       // ack answer blocked by the message transfer
        do_plain(FN_TX_DONE);
        clock_ms = 32'h0000_0010;
        do_rx(1'b1, 8'd0, 1'b0, 6'd0, 8'd0); // expected ack across the time wrap
        do_read(8'd0);                       // answered with an ack frame
        do_send(8'd10, 6'd5, 1'b0);          // busy sending the ack
        do_plain(FN_TX_DONE);
        do_mode(MODE_LISTEN);
        do_rx(1'b0, 8'd255, 1'b0, 6'd0, 8'd1);  // longest length byte
        do_read(8'd255);                     // held payload over max_rx_length
        do_mode(MODE_RX);
        do_rx(1'b0, 8'd11, 1'b0, 6'd5, 8'd128);
        do_read(8'd9);                       // buffer one short
        do_read(8'd10);

        // Random phases: both extremes first, then random settings; some phases
        // start just below the 32-bit time wrap.
        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0: set_config(MODE_SLEEP, 16'd0, 6'd0, 7'd1);
                1: set_config(MODE_LISTEN, 16'hFFFF, 6'd63, 7'd64);
                default:
                    set_config(3'($urandom_range(0, 5)),
                               ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                           : 16'($urandom_range(0, 200)),
                               6'($urandom_range(0, 63)), 7'($urandom_range(1, 64)));
            endcase
            if (p % 3 == 1)
                clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 5000);
            run_traffic(230);
        end

        drain();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[packet_radio_ack_link_controller.f]
rtl/core/prack_pkg.sv
rtl/core/prack_step.sv
rtl/core/prack_stats.sv
rtl/core/packet_radio_ack_link_controller.sv
tb/prack_link_checker.sv
tb/packet_radio_ack_link_controller_test.sv
